// File: src/mkd_pkg.sv
// ----------------------------------------------------------------------------
// mkd_pkg: shared types and constants of the Morse key decoder
// Holds configuration defaults and register indexes, the event struct passed
// from the press timer to the symbol buffer, and the Morse code lookup.
// ----------------------------------------------------------------------------
package mkd_pkg;

  localparam int CFG_WIDTH   = 24;
  localparam int MAX_SYMBOLS = 5;
  localparam int COUNT_WIDTH = 3;
  localparam int CHAR_WIDTH  = 7;

  localparam logic [CFG_WIDTH-1:0] DOT_MIN_RESET   = 24'd60000;
  localparam logic [CFG_WIDTH-1:0] DASH_MIN_RESET  = 24'd533333;
  localparam logic [CFG_WIDTH-1:0] DASH_MAX_RESET  = 24'd1066666;
  localparam logic [CFG_WIDTH-1:0] GAP_TICKS_RESET = 24'd1114112;

  typedef enum logic [1:0] {
    CFG_DOT_MIN   = 2'd0,
    CFG_DASH_MIN  = 2'd1,
    CFG_DASH_MAX  = 2'd2,
    CFG_GAP_TICKS = 2'd3
  } mkd_cfg_idx_t;

  // What one key sample did to the timing state.
  typedef struct packed {
    logic sym_valid;  // a press was classified as dot or dash
    logic sym_dash;   // the classified press was a dash
    logic gap;        // the inter-letter gap expired
  } mkd_event_t;

  // Morse tree lookup. Index is (1 << length) + code, first symbol in the
  // MSB of the code and a dash encoded as 1.
  function automatic logic [CHAR_WIDTH-1:0] mkd_lookup(input logic [5:0] idx);
    logic [CHAR_WIDTH-1:0] ch;
    unique case (idx)
      6'd2:    ch = 7'h45;  // E
      6'd3:    ch = 7'h54;  // T
      6'd4:    ch = 7'h49;  // I
      6'd5:    ch = 7'h41;  // A
      6'd6:    ch = 7'h4E;  // N
      6'd7:    ch = 7'h4D;  // M
      6'd8:    ch = 7'h53;  // S
      6'd9:    ch = 7'h55;  // U
      6'd10:   ch = 7'h52;  // R
      6'd11:   ch = 7'h57;  // W
      6'd12:   ch = 7'h44;  // D
      6'd13:   ch = 7'h4B;  // K
      6'd14:   ch = 7'h47;  // G
      6'd15:   ch = 7'h4F;  // O
      6'd16:   ch = 7'h48;  // H
      6'd17:   ch = 7'h56;  // V
      6'd18:   ch = 7'h46;  // F
      6'd20:   ch = 7'h4C;  // L
      6'd22:   ch = 7'h50;  // P
      6'd23:   ch = 7'h4A;  // J
      6'd24:   ch = 7'h42;  // B
      6'd25:   ch = 7'h58;  // X
      6'd26:   ch = 7'h43;  // C
      6'd27:   ch = 7'h59;  // Y
      6'd28:   ch = 7'h5A;  // Z
      6'd29:   ch = 7'h51;  // Q
      6'd32:   ch = 7'h35;  // 5
      6'd33:   ch = 7'h34;  // 4
      6'd35:   ch = 7'h33;  // 3
      6'd39:   ch = 7'h32;  // 2
      6'd47:   ch = 7'h31;  // 1
      6'd48:   ch = 7'h36;  // 6
      6'd56:   ch = 7'h37;  // 7
      6'd60:   ch = 7'h38;  // 8
      6'd62:   ch = 7'h39;  // 9
      6'd63:   ch = 7'h30;  // 0
      default: ch = '0;
    endcase
    return ch;
  endfunction

  // Turns the buffer (symbol i in bit i) into a character, or 0 if the
  // code is empty or has no entry.
  function automatic logic [CHAR_WIDTH-1:0] mkd_decode(
    input logic [MAX_SYMBOLS-1:0] bits,
    input logic [COUNT_WIDTH-1:0] count
  );
    logic [MAX_SYMBOLS-1:0] code;
    logic [5:0]             idx;
    code = '0;
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      if (COUNT_WIDTH'(i) < count) begin
        code = {code[MAX_SYMBOLS-2:0], bits[i]};
      end
    end
    idx = (6'd1 << count) | 6'(code);
    if (count == '0 || count > COUNT_WIDTH'(MAX_SYMBOLS)) begin
      return '0;
    end
    return mkd_lookup(idx);
  endfunction

endpackage

// File: src/mkd_press_timer.sv
// ----------------------------------------------------------------------------
// mkd_press_timer: key edge detection, press and gap timing
// Times each press with a saturating counter, classifies it as dot or dash
// on release, and signals when the inter-letter gap has expired.
// ----------------------------------------------------------------------------
module mkd_press_timer
  import mkd_pkg::*;
#(
  parameter int TICK_COUNT_WIDTH = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 level,
  input  logic [CFG_WIDTH-1:0] dot_min,
  input  logic [CFG_WIDTH-1:0] dash_min,
  input  logic [CFG_WIDTH-1:0] dash_max,
  input  logic [CFG_WIDTH-1:0] gap_ticks,
  output mkd_event_t           evt
);

  localparam int TW = TICK_COUNT_WIDTH;
  localparam int CmpWidth = (TW > CFG_WIDTH) ? TW : CFG_WIDTH;

  logic          last_level;
  logic [TW-1:0] press_ticks, press_ticks_next;
  logic [TW-1:0] idle_ticks, idle_ticks_next;
  logic [TW-1:0] idle_inc;
  logic          rise, fall;
  logic          is_dot, is_dash;
  logic [CmpWidth-1:0] len_x, idle_x, dot_min_x, dash_min_x, dash_max_x, gap_x;

  assign rise = level & ~last_level;
  assign fall = ~level & last_level;

  assign len_x      = CmpWidth'(press_ticks);
  assign idle_x     = CmpWidth'(idle_inc);
  assign dot_min_x  = CmpWidth'(dot_min);
  assign dash_min_x = CmpWidth'(dash_min);
  assign dash_max_x = CmpWidth'(dash_max);
  assign gap_x      = CmpWidth'(gap_ticks);

  assign is_dot  = (len_x > dot_min_x) && (len_x < dash_min_x);
  assign is_dash = !is_dot && (len_x > dash_min_x) && (len_x < dash_max_x);

  assign idle_inc = (idle_ticks == '1) ? idle_ticks : idle_ticks + TW'(1);

  always_comb begin
    press_ticks_next = press_ticks;
    idle_ticks_next  = idle_ticks;
    evt              = '0;
    if (rise) begin
      press_ticks_next = TW'(1);
      idle_ticks_next  = '0;
    end else if (fall) begin
      idle_ticks_next = '0;
      evt.sym_valid   = is_dot | is_dash;
      evt.sym_dash    = is_dash;
    end else begin
      if (level && press_ticks != '1) begin
        press_ticks_next = press_ticks + TW'(1);
      end
      if (idle_x >= gap_x) begin
        idle_ticks_next = '0;
        evt.gap         = 1'b1;
      end else begin
        idle_ticks_next = idle_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level  <= 1'b0;
      press_ticks <= '0;
      idle_ticks  <= '0;
    end else if (step) begin
      last_level  <= level;
      press_ticks <= press_ticks_next;
      idle_ticks  <= idle_ticks_next;
    end
  end

endmodule

// File: src/mkd_symbol_buffer.sv
// ----------------------------------------------------------------------------
// mkd_symbol_buffer: dot/dash buffer and letter decode
// Collects up to five symbols and decodes them to ASCII when the buffer
// fills or the gap expires, clearing the buffer on every flush.
// ----------------------------------------------------------------------------
module mkd_symbol_buffer
  import mkd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  mkd_event_t            evt,
  output logic                  letter_valid,
  output logic [CHAR_WIDTH-1:0] letter_char
);

  logic [MAX_SYMBOLS-1:0] symbol_bits, symbol_bits_next;
  logic [COUNT_WIDTH-1:0] symbol_count, symbol_count_next;
  logic                   flush;
  logic [CHAR_WIDTH-1:0]  ch;

  always_comb begin
    symbol_bits_next  = symbol_bits;
    symbol_count_next = symbol_count;
    if (evt.sym_valid && symbol_count < COUNT_WIDTH'(MAX_SYMBOLS)) begin
      symbol_bits_next[symbol_count] = evt.sym_dash;
      symbol_count_next              = symbol_count + COUNT_WIDTH'(1);
    end
    flush = evt.gap || (symbol_count_next >= COUNT_WIDTH'(MAX_SYMBOLS));
    ch    = flush ? mkd_decode(symbol_bits_next, symbol_count_next) : '0;
    if (flush) begin
      symbol_bits_next  = '0;
      symbol_count_next = '0;
    end
  end

  assign letter_valid = (ch != '0);
  assign letter_char  = ch;

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_bits  <= '0;
      symbol_count <= '0;
    end else if (step) begin
      symbol_bits  <= symbol_bits_next;
      symbol_count <= symbol_count_next;
    end
  end

  // A full buffer is always flushed in the same step that fills it.
  a_count_below_full: assert property (@(posedge clk) disable iff (rst)
    symbol_count < COUNT_WIDTH'(MAX_SYMBOLS))
    else $error("symbol buffer held a full count across a step");

  // Buffer positions at or above the count are always clear.
  a_bits_above_count_clear: assert property (@(posedge clk) disable iff (rst)
    (symbol_bits >> symbol_count) == '0)
    else $error("symbol buffer has a dash beyond its count");

endmodule

// File: src/morse_key_decoder_core.sv
// ----------------------------------------------------------------------------
// morse_key_decoder_core: Morse key decoder, one key sample per timer tick
// Turns a stream of key-line samples into dot/dash symbols and ASCII
// letters and digits.
// ----------------------------------------------------------------------------
// Usage:
// Each beat on the key channel (key_valid/key_ready/key_level) carries one
// sample of the key line for one timer tick. A beat on the result channel
// (result_valid/result_ready) is produced only for ticks that classified a
// press as dot or dash, or that decoded a letter; other ticks only update
// the timing state. The four configuration registers are written through
// cfg_we/cfg_index/cfg_data only while the block is idle; the user is bound
// to this, and nothing in the block enforces it. A sample is captured in
// an input register; the timing and buffer state are then updated and the
// result register loaded from it. One sample is taken in every cycle while
// the receiver does not stall.
// When the receiver stalls, the result register holds its beat while the
// input register keeps one more sample; only when both are full does
// key_ready drop. Reset clears the timing counters, the symbol buffer,
// both pipeline registers and loads the default thresholds.
// ----------------------------------------------------------------------------
module morse_key_decoder_core
  import mkd_pkg::*;
#(
  parameter int TICK_COUNT_WIDTH = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  // key sample channel
  input  logic                  key_valid,
  output logic                  key_ready,
  input  logic                  key_level,
  // result channel
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic                  symbol_valid,
  output logic                  symbol_is_dash,
  output logic                  letter_valid,
  output logic [CHAR_WIDTH-1:0] letter_char,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_WIDTH-1:0]  cfg_data
);

  // Threshold registers.
  logic [CFG_WIDTH-1:0] dot_min, dash_min, dash_max, gap_ticks;

  // Input register holding one captured sample.
  logic stage_valid;
  logic stage_level;

  logic       advance;
  logic       step;
  mkd_event_t evt;
  logic       buf_letter_valid;
  logic [CHAR_WIDTH-1:0] buf_letter_char;
  logic       has_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_min   <= DOT_MIN_RESET;
      dash_min  <= DASH_MIN_RESET;
      dash_max  <= DASH_MAX_RESET;
      gap_ticks <= GAP_TICKS_RESET;
    end else if (cfg_we) begin
      unique case (mkd_cfg_idx_t'(cfg_index))
        CFG_DOT_MIN:   dot_min   <= cfg_data;
        CFG_DASH_MIN:  dash_min  <= cfg_data;
        CFG_DASH_MAX:  dash_max  <= cfg_data;
        CFG_GAP_TICKS: gap_ticks <= cfg_data;
      endcase
    end
  end

  // The stage moves forward whenever the result register is free or is
  // being emptied this cycle; a sample with no result still advances.
  assign advance   = !result_valid || result_ready;
  assign step      = stage_valid && advance;
  assign key_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (key_valid && key_ready) begin
      stage_valid <= 1'b1;
    end else if (step) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (key_valid && key_ready) begin
      stage_level <= key_level;
    end
  end

  mkd_press_timer #(
    .TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
  ) u_timer (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .level     (stage_level),
    .dot_min   (dot_min),
    .dash_min  (dash_min),
    .dash_max  (dash_max),
    .gap_ticks (gap_ticks),
    .evt       (evt)
  );

  mkd_symbol_buffer u_buffer (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .evt          (evt),
    .letter_valid (buf_letter_valid),
    .letter_char  (buf_letter_char)
  );

  assign has_result = evt.sym_valid || buf_letter_valid;

  // Result register: loaded on every step, emptied when the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step) begin
      result_valid <= has_result;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      symbol_valid   <= evt.sym_valid;
      symbol_is_dash <= evt.sym_valid && evt.sym_dash;
      letter_valid   <= buf_letter_valid;
      letter_char    <= buf_letter_char;
    end
  end

  // Every result beat carries a symbol or a letter.
  a_result_not_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (symbol_valid || letter_valid))
    else $error("result beat with neither symbol nor letter");

  // A letter beat always carries a nonzero character.
  a_letter_has_char: assert property (@(posedge clk) disable iff (rst)
    (result_valid && letter_valid) |-> (letter_char != '0))
    else $error("letter beat with a null character");

  // A stalled result keeps its contents until it is taken.
  a_stall_keeps_letter: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> $stable(letter_char) && result_valid)
    else $error("stalled result beat changed");

  // The stage never consumes a sample while the result register is blocked.
  a_no_step_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |-> !step)
    else $error("sample processed into a blocked result register");

endmodule
